// ===== hdl/bb3s_pkg.sv =====
// ----------------------------------------------------------------------------
// bb3s_pkg
// shared types, constants and the divisor reciprocal table for the strip blur
// ----------------------------------------------------------------------------
package bb3s_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 4096;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int WID_W      = 11;
	localparam int HGT_W      = 13;
	localparam int PIX_W      = 24;
	localparam int SUM_W      = 12;
	localparam int CNT_W      = 4;
	localparam int RCP_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DAT_W  = 13;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UPPER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOWER  = 3'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_UPD,
		ST_SUM,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic accept;
		logic update;
		logic sum;
		logic load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic res;
		logic out_free;
	} dp_stat_t;

	// ceil(2^16 / n): exact floor division for sums below 4096
	function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
		logic [RCP_W-1:0] r;
		unique case (n)
			4'd2:    r = 17'd32768;
			4'd3:    r = 17'd21846;
			4'd4:    r = 17'd16384;
			4'd5:    r = 17'd13108;
			4'd6:    r = 17'd10923;
			4'd7:    r = 17'd9363;
			4'd8:    r = 17'd8192;
			4'd9:    r = 17'd7282;
			default: r = 17'd65536;
		endcase
		return r;
	endfunction

endpackage

// ===== hdl/box_blur_3x3_strip.sv =====
// ----------------------------------------------------------------------------
// box_blur_3x3_strip
// items are handled one at a time: accept/read, line store write, window sum and,
// for an item with a result, divide into the output register once it is free; a new
//   item is accepted only after the last one is through this item sequencer
// reset: arst_n clears counters and window, sets configuration to defaults; line stores undefined
// ----------------------------------------------------------------------------
module box_blur_3x3_strip import bb3s_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [23:0]          s_axis_tdata,   // red_in, green_in, blue_in
	input  logic                 s_axis_tuser,   // operation
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [23:0]          m_axis_tdata,   // red_out, green_out, blue_out
	output logic                 m_axis_tlast,   // frame_last
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign cfg_ready = 1'b1;

	bb3s_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	bb3s_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.op_drain  (s_axis_tuser),
		.pix_in    (s_axis_tdata),
		.cfg_we    (cfg_valid),
		.cfg_idx   (cfg_index),
		.cfg_dat   (cfg_data),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_pix   (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== hdl/bb3s_ctrl.sv =====
// ----------------------------------------------------------------------------
// bb3s_ctrl
// item sequencer: accept, line store update, window sum, result load
// ----------------------------------------------------------------------------
module bb3s_ctrl import bb3s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_UPD;
			ST_UPD:  state_d = ST_SUM;
			ST_SUM:  state_d = stat.res ? ST_OUT : ST_IDLE;
			ST_OUT:  if (stat.out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = (state_q == ST_IDLE);
		cmd.accept = (state_q == ST_IDLE) && in_valid;
		cmd.update = (state_q == ST_UPD);
		cmd.sum    = (state_q == ST_SUM);
		cmd.load   = (state_q == ST_OUT) && stat.out_free;
	end

`ifndef SYNTH
	a_upd_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> cmd.update) else $error("update does not follow accept");
	a_sum_after_upd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update |=> cmd.sum) else $error("sum does not follow update");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.update || cmd.sum) |-> !in_ready) else $error("ready while busy");
`endif

endmodule

// ===== hdl/bb3s_dp.sv =====
// ----------------------------------------------------------------------------
// bb3s_dp
// line stores, 3x3 window, position counters, masked sums and mean division
// ----------------------------------------------------------------------------
module bb3s_dp import bb3s_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctrl_cmd_t            cmd,
	output dp_stat_t             stat,
	input  logic                 op_drain,
	input  logic [PIX_W-1:0]     pix_in,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_DAT_W-1:0] cfg_dat,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [PIX_W-1:0]     out_pix,
	output logic                 out_last
);

	logic [WID_W-1:0] width_q;
	logic [HGT_W-1:0] height_q;
	logic             up_q, lo_q;
	logic             restart_cfg;

	logic [PIX_W-1:0] mem_a [MAX_WIDTH];
	logic [PIX_W-1:0] mem_b [MAX_WIDTH];
	logic [PIX_W-1:0] pix_q, above_q, older_q;
	logic [PIX_W-1:0] win_q [9];

	logic [COL_W-1:0] col_q;
	logic [HGT_W-1:0] row_q;
	logic             res_q, last_q;
	logic [2:0]       rmask_q, cmask_q;
	logic [SUM_W-1:0] sum_q [3];
	logic [CNT_W-1:0] cnt_q;
	logic             ovalid_q, olast_q;
	logic [PIX_W-1:0] opix_q;

	logic [WID_W-1:0] w_eff, cc;
	logic [HGT_W-1:0] h_eff;
	logic signed [15:0] s16, sc, rel, rows, hh;
	logic             res_d, last_d;
	logic [2:0]       rmask_d, cmask_d;
	logic [SUM_W-1:0] sum_d [3];
	logic [CNT_W-1:0] cnt_d;
	logic [WID_W-1:0] col_inc;
	logic [RCP_W-1:0] rcp;
	logic [SUM_W+RCP_W-1:0] prod [3];

	assign restart_cfg = cfg_we && (cfg_idx == CFG_WIDTH || cfg_idx == CFG_HEIGHT ||
		cfg_idx == CFG_UPPER || cfg_idx == CFG_LOWER);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WID_W'(MAX_WIDTH);
			height_q <= HGT_W'(1024);
			up_q     <= 1'b0;
			lo_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_WIDTH:  width_q  <= cfg_dat[WID_W-1:0];
				CFG_HEIGHT: height_q <= cfg_dat;
				CFG_UPPER:  up_q     <= cfg_dat[0];
				CFG_LOWER:  lo_q     <= cfg_dat[0];
				default: ;
			endcase
		end
	end

	// saturate to the legal range
	always_comb begin
		if (width_q == '0) w_eff = WID_W'(1);
		else if (width_q > WID_W'(MAX_WIDTH)) w_eff = WID_W'(MAX_WIDTH);
		else w_eff = width_q;
		if (height_q == '0) h_eff = HGT_W'(1);
		else if (height_q > HGT_W'(MAX_HEIGHT)) h_eff = HGT_W'(MAX_HEIGHT);
		else h_eff = height_q;
	end

	// line stores: read on accept, written back on update
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			pix_q   <= op_drain ? '0 : pix_in;
			above_q <= mem_a[col_q];
			older_q <= mem_b[col_q];
		end
		if (cmd.update) begin
			mem_a[col_q] <= pix_q;
			mem_b[col_q] <= above_q;
		end
	end

	// centre position and neighbour masks
	always_comb begin
		s16  = signed'({3'b000, row_q});
		sc   = (col_q != '0) ? s16 - 16'sd1 : s16 - 16'sd2;
		cc   = (col_q != '0) ? WID_W'(col_q) - WID_W'(1) : w_eff - WID_W'(1);
		hh   = signed'({3'b000, h_eff});
		rel  = sc - signed'({15'd0, up_q});
		rows = hh + signed'({15'd0, up_q}) + signed'({15'd0, lo_q});
		res_d  = (rel >= 16'sd0) && (rel < hh);
		last_d = (rel == hh - 16'sd1) && (cc == w_eff - WID_W'(1));
		rmask_d = {(sc + 16'sd1 < rows), (sc >= 16'sd0), (sc >= 16'sd1)};
		cmask_d = {(cc + WID_W'(1) < w_eff), 1'b1, (cc != '0)};
	end

	always_comb begin
		for (int ch = 0; ch < 3; ch++) sum_d[ch] = '0;
		cnt_d = '0;
		for (int i = 0; i < 9; i++) begin
			if (rmask_q[i/3] && cmask_q[i%3]) begin
				for (int ch = 0; ch < 3; ch++)
					sum_d[ch] = sum_d[ch] + SUM_W'(win_q[i][ch*8 +: 8]);
				cnt_d = cnt_d + CNT_W'(1);
			end
		end
	end

	assign col_inc = WID_W'(col_q) + WID_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			col_q   <= '0;
			row_q   <= '0;
			res_q   <= 1'b0;
			last_q  <= 1'b0;
			rmask_q <= '0;
			cmask_q <= '0;
		end else if (restart_cfg) begin
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.update) begin
			for (int k = 0; k < 3; k++) begin
				win_q[k*3]   <= win_q[k*3+1];
				win_q[k*3+1] <= win_q[k*3+2];
			end
			win_q[2] <= older_q;
			win_q[5] <= above_q;
			win_q[8] <= pix_q;
			res_q    <= res_d;
			last_q   <= last_d;
			rmask_q  <= rmask_d;
			cmask_q  <= cmask_d;
		end else if (cmd.sum) begin
			if (res_q && last_q) begin
				for (int i = 0; i < 9; i++) win_q[i] <= '0;
				col_q <= '0;
				row_q <= '0;
			end else if (col_inc >= w_eff) begin
				col_q <= '0;
				if (row_q != '1) row_q <= row_q + HGT_W'(1);
			end else begin
				col_q <= col_inc[COL_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			for (int ch = 0; ch < 3; ch++) sum_q[ch] <= sum_d[ch];
			cnt_q   <= cnt_d;
			olast_q <= last_q;
		end
	end

	// reciprocal multiply, exact for sums below 4096 and divisors 1..9
	always_comb begin
		rcp = recip(cnt_q);
		for (int ch = 0; ch < 3; ch++)
			prod[ch] = (SUM_W+RCP_W)'(sum_q[ch]) * (SUM_W+RCP_W)'(rcp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			for (int ch = 0; ch < 3; ch++) opix_q[ch*8 +: 8] <= prod[ch][23:16];
			out_last <= olast_q;
		end
	end

	assign out_valid     = ovalid_q;
	assign out_pix       = opix_q;
	assign stat.res      = res_q;
	assign stat.out_free = !ovalid_q || out_ready;

`ifndef SYNTH
	a_col_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		WID_W'(col_q) < w_eff || $past(cfg_we)) else $error("column beyond width");
	a_load_has_res: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> res_q) else $error("result load without result");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		($past(cmd.sum) && res_q) |-> (cnt_q >= CNT_W'(1) && cnt_q <= CNT_W'(9)))
		else $error("neighbour count out of range");
`endif

endmodule

// ===== tb/tb_box_blur_3x3_strip.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_strip
// self-checking bench: an in-bench model of the strip mean filter predicts each
// output pixel from the accepted input stream and register writes; strips of
// random and extreme geometry are streamed with random stalls on both sides
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_strip;
	import bb3s_pkg::*;

	typedef struct {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       last;
	} blur_px_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [23:0]          s_axis_tdata;   // red_in, green_in, blue_in
	logic                 s_axis_tuser;   // operation
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [23:0]          m_axis_tdata;   // red_out, green_out, blue_out
	logic                 m_axis_tlast;   // frame_last
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	box_blur_3x3_strip u_top (.*);

	// filter model state
	int          mdl_width, mdl_height, mdl_upper, mdl_lower;
	logic [23:0] row_prev[MAX_WIDTH];
	logic [23:0] row_older[MAX_WIDTH];
	logic [23:0] win[9];
	int          row_pos, col_pos;
	bit          strip_done;

	blur_px_t expected_pixels[$];
	int       err_cnt;
	bit       no_idle;
	int       stall_cycles;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("%0t ERROR %s", $realtime, msg);
		err_cnt++;
	endtask

	function automatic void restart_strip();
		row_pos = 0;
		col_pos = 0;
		foreach (win[i]) win[i] = '0;
	endfunction

	// one item through the filter model; returns 1 when it yields a pixel
	function automatic bit blur_step(input bit drain, input logic [23:0] px_in,
			output blur_px_t res);
		int w, h, rows, c, s, sc, cc, nr, nc, cnt;
		int sr, sg, sb;
		logic [23:0] px, above, older, v;
		bit lst;
		w = (mdl_width < 1) ? 1 : (mdl_width > MAX_WIDTH) ? MAX_WIDTH : mdl_width;
		h = (mdl_height < 1) ? 1 : (mdl_height > MAX_HEIGHT) ? MAX_HEIGHT : mdl_height;
		rows = mdl_upper + h + mdl_lower;
		c = col_pos % MAX_WIDTH;
		s = row_pos;
		px = drain ? 24'd0 : px_in;
		above = row_prev[c];
		older = row_older[c];
		row_older[c] = above;
		row_prev[c] = px;
		for (int k = 0; k < 3; k++) begin
			win[k*3]   = win[k*3+1];
			win[k*3+1] = win[k*3+2];
		end
		win[2] = older;
		win[5] = above;
		win[8] = px;
		if (c >= 1) begin
			sc = s - 1; cc = c - 1;
		end else begin
			sc = s - 2; cc = w - 1;
		end
		if (sc - mdl_upper >= 0 && sc - mdl_upper < h) begin
			sr = 0; sg = 0; sb = 0; cnt = 0;
			for (int dr = 0; dr < 3; dr++) begin
				nr = sc - 1 + dr;
				if (nr < 0 || nr >= rows) continue;
				for (int dc = 0; dc < 3; dc++) begin
					nc = cc - 1 + dc;
					if (nc < 0 || nc >= w) continue;
					v = win[dr*3+dc];
					sr += v[7:0];
					sg += v[15:8];
					sb += v[23:16];
					cnt++;
				end
			end
			if (cnt == 0) cnt = 1;
			lst = (sc == mdl_upper + h - 1) && (cc == w - 1);
			res.red   = 8'(sr / cnt);
			res.green = 8'(sg / cnt);
			res.blue  = 8'(sb / cnt);
			res.last  = lst;
			if (lst) begin
				restart_strip();
				strip_done = 1'b1;
				return 1'b1;
			end
		end else begin
			res = '{default: '0};
		end
		c++;
		if (c >= w) begin
			c = 0;
			if (row_pos < 8191) row_pos++;
		end
		col_pos = c;
		return (sc - mdl_upper >= 0 && sc - mdl_upper < h);
	endfunction

	// output checker
	always @(posedge clk) begin
		blur_px_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch($sformatf("unexpected pixel %h last %b",
					m_axis_tdata, m_axis_tlast));
			end else begin
				e = expected_pixels.pop_front();
				if (m_axis_tdata[7:0] !== e.red)
					report_mismatch($sformatf("red %h exp %h", m_axis_tdata[7:0], e.red));
				if (m_axis_tdata[15:8] !== e.green)
					report_mismatch($sformatf("green %h exp %h", m_axis_tdata[15:8],
						e.green));
				if (m_axis_tdata[23:16] !== e.blue)
					report_mismatch($sformatf("blue %h exp %h", m_axis_tdata[23:16],
						e.blue));
				if (m_axis_tlast !== e.last)
					report_mismatch($sformatf("last %b exp %b", m_axis_tlast, e.last));
			end
		end
	end

	// output back-pressure in bursts
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (!no_idle && $urandom_range(0, 3) == 0) begin
				m_axis_tready <= 1'b0;
				repeat ($urandom_range(1, 12) - 1) @(negedge clk);
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog: cycles with no transaction anywhere
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= 4000) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	task automatic send_item(input bit drain, input logic [23:0] px);
		blur_px_t r;
		if (!no_idle && $urandom_range(0, 4) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= drain;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		if (blur_step(drain, px, r)) expected_pixels.push_back(r);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		// items with no pixel may still be in flight
		repeat (10) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_DAT_W-1:0];
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_WIDTH:  mdl_width  = val & 'h7FF;
			CFG_HEIGHT: mdl_height = val & 'h1FFF;
			CFG_UPPER:  mdl_upper  = val & 1;
			CFG_LOWER:  mdl_lower  = val & 1;
			default: ;
		endcase
		restart_strip();
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [23:0] rand_pixel();
		logic [23:0] p;
		p = 24'($urandom);
		for (int k = 0; k < 3; k++)
			case ($urandom_range(0, 7))
				0: p[k*8 +: 8] = 8'h00;
				1: p[k*8 +: 8] = 8'hFF;
				default: ;
			endcase
		return p;
	endfunction

	// fill: 0 random, 1 all full scale, 2 all zero
	task automatic run_strip(input int w, input int h, input int up, input int lo,
			input int fill, input bit drains_inside);
		int w_eff, h_eff, n;
		logic [23:0] px;
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_UPPER, up);
		write_reg(CFG_LOWER, lo);
		w_eff = (w < 1) ? 1 : (w > MAX_WIDTH) ? MAX_WIDTH : w;
		h_eff = (h < 1) ? 1 : (h > MAX_HEIGHT) ? MAX_HEIGHT : h;
		n = w_eff * (h_eff + up + lo);
		strip_done = 1'b0;
		for (int i = 0; i < n && !strip_done; i++) begin
			px = (fill == 1) ? 24'hFFFFFF : (fill == 2) ? 24'h0 : rand_pixel();
			send_item(drains_inside && $urandom_range(0, 15) == 0, px);
		end
		// flush the tail
		while (!strip_done) send_item(1'b1, rand_pixel());
	endtask

	task automatic test_directed();
		run_strip(3, 3, 0, 0, 1, 0);
		run_strip(3, 1, 1, 1, 2, 0);
		run_strip(2, 2, 1, 0, 0, 1);
		run_strip(0, 0, 0, 1, 0, 0);
		run_strip(1, 2, 1, 1, 0, 1);
	endtask

	task automatic test_extreme_sizes();
		run_strip(1, 12, 1, 1, 1, 0);
		run_strip(33, 1, 0, 0, 0, 1);
		run_strip(2, 0, 1, 1, 0, 0);
	endtask

	task automatic test_random_strips(input int items);
		int sent;
		int w, h;
		sent = 0;
		while (sent < items) begin
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			run_strip(w, h, $urandom_range(0, 1), $urandom_range(0, 1), 0,
				$urandom_range(0, 1));
			sent += w * (h + 2) + w + 1;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		err_cnt = 0;
		no_idle = 1'b0;
		stall_cycles = 0;
		mdl_width = 1024;
		mdl_height = 1024;
		mdl_upper = 0;
		mdl_lower = 0;
		foreach (row_prev[i]) begin
			row_prev[i] = '0;
			row_older[i] = '0;
		end
		restart_strip();
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		test_extreme_sizes();
		test_random_strips(400);
		no_idle = 1'b1;
		test_random_strips(100);

		s_axis_tvalid <= 1'b0;
		while (expected_pixels.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
		if (err_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
